@@ rtl/pfa_pkg.sv @@
// shared widths, request codes, status codes and register indexes of the page frame allocator
`default_nettype none

package pfa_pkg;

   // field widths of the request, result and register ports
   localparam int REQ_W    = 3;
   localparam int IDX_W    = 10;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 16;
   localparam int CFG_W    = 11;
   localparam int CSR_IX_W = 1;

   // request codes
   localparam logic [REQ_W-1:0] REQ_INIT  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd1;
   localparam logic [REQ_W-1:0] REQ_FREE  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_ADD   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_DROP  = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOMEM  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISUSE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IX_W-1:0] CSR_NUM_PAGES = 1'd0;
   localparam logic [CSR_IX_W-1:0] CSR_RESERVED  = 1'd1;

   // configuration reset values
   localparam logic [CFG_W-1:0] NUM_PAGES_RST = 11'd1024;
   localparam logic [CFG_W-1:0] RESERVED_RST  = 11'd0;

endpackage

`default_nettype wire

@@ rtl/pfa_ram.sv @@
// simple dual-port synchronous ram with one write port and one registered read port
`default_nettype none

module pfa_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

@@ rtl/page_frame_allocator_top.sv @@
// page frame allocator: lifo free list and per-page reference counts kept in two rams
// alloc, free, add and drop read the rams when accepted, then modify and write back in S_MOD;
//   an out-of-range index, an empty list or an unknown code answers in the cycle after the request
// alloc, free, add and drop hold busy high through S_MOD: no new request is taken until their write back
// init sweeps every page, one per cycle, with busy high; result in the cycle after the last page
// reset: a clearing pass over every page zeroes counts and flags, busy stays high meanwhile
// the receiver cannot stall: each result strobe lasts exactly one cycle
`default_nettype none

module page_frame_allocator_top #(
   parameter int MAX_PAGES = 1024,
   parameter int REF_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [pfa_pkg::REQ_W-1:0]     req_type,
   input  wire logic [pfa_pkg::IDX_W-1:0]     req_page_index,
   output logic                               rsp_valid,
   output logic      [pfa_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [pfa_pkg::IDX_W-1:0]     rsp_given_page,
   output logic      [pfa_pkg::CNT_W-1:0]     rsp_ref_count,
   output logic                               rsp_returned_to_list,
   input  wire logic                          csr_we,
   input  wire logic [pfa_pkg::CSR_IX_W-1:0]  csr_index,
   input  wire logic [pfa_pkg::CFG_W-1:0]     csr_wdata
);

   localparam int PW    = $clog2(MAX_PAGES);
   localparam int FW    = $clog2(MAX_PAGES + 1);
   localparam int CMPW  = (FW > pfa_pkg::CFG_W) ? FW : pfa_pkg::CFG_W;
   localparam int MetaW = REF_BITS + 1;
   localparam int PageW = pfa_pkg::IDX_W;
   localparam int CntW  = pfa_pkg::CNT_W;

   localparam logic [PW-1:0]       LastPage = PW'(MAX_PAGES - 1);
   localparam logic [FW-1:0]       FullCnt  = FW'(MAX_PAGES);
   localparam logic [CMPW-1:0]     MaxCmp   = CMPW'(MAX_PAGES);
   localparam logic [REF_BITS-1:0] RefMax   = '1;
   localparam logic [REF_BITS-1:0] RefOne   = REF_BITS'(1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_INIT,
      S_MOD
   } state_type;

   // registers
   state_type                      state_ff, state_in;
   logic [PW-1:0]                  sweep_ff, sweep_in;
   logic [FW-1:0]                  fc_ff, fc_in;
   logic [pfa_pkg::REQ_W-1:0]      op_ff, op_in;
   logic [PW-1:0]                  idx_ff, idx_in;
   logic [pfa_pkg::CFG_W-1:0]      num_pages_ff, num_pages_in;
   logic [pfa_pkg::CFG_W-1:0]      reserved_ff, reserved_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pfa_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [PageW-1:0]               rsp_given_ff, rsp_given_in;
   logic [CntW-1:0]                rsp_count_ff, rsp_count_in;
   logic                           rsp_back_ff, rsp_back_in;

   // ram ports
   logic                meta_we;
   logic [PW-1:0]       meta_waddr;
   logic [MetaW-1:0]    meta_wdata;
   logic [PW-1:0]       meta_raddr;
   logic [MetaW-1:0]    meta_rdata;
   logic                stack_we;
   logic [PW-1:0]       stack_waddr;
   logic [PW-1:0]       stack_wdata;
   logic [PW-1:0]       stack_raddr;
   logic [PW-1:0]       stack_rdata;

   // helpers
   logic [CMPW-1:0]     num_ext;
   logic [CMPW-1:0]     res_ext;
   logic [CMPW-1:0]     npg;
   logic [CMPW-1:0]     res_clip;
   logic [CMPW-1:0]     idx_ext;
   logic [CMPW-1:0]     sweep_ext;
   logic                in_range;
   logic [PW-1:0]       req_idx;
   logic [FW-1:0]       fc_dec;
   logic                fc_full;
   logic                cur_flag;
   logic [REF_BITS-1:0] cur_refs;
   logic [REF_BITS-1:0] new_refs;
   logic                push_ok;
   logic                sweep_last;

   // count/flag ram: {on free list, reference count} per page
   pfa_ram #(
      .WIDTH (MetaW),
      .DEPTH (MAX_PAGES)
   ) u_meta_ram (
      .clock (clock),
      .we    (meta_we),
      .waddr (meta_waddr),
      .wdata (meta_wdata),
      .raddr (meta_raddr),
      .rdata (meta_rdata)
   );

   // free stack ram
   pfa_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_PAGES)
   ) u_stack_ram (
      .clock (clock),
      .we    (stack_we),
      .waddr (stack_waddr),
      .wdata (stack_wdata),
      .raddr (stack_raddr),
      .rdata (stack_rdata)
   );

   // usable page count, clipped reserve boundary and range check
   always_comb begin
      num_ext   = CMPW'(num_pages_ff);
      res_ext   = CMPW'(reserved_ff);
      npg       = (num_ext < MaxCmp) ? num_ext : MaxCmp;
      res_clip  = (res_ext < npg) ? res_ext : npg;
      idx_ext   = CMPW'(req_page_index);
      in_range  = idx_ext < npg;
      req_idx   = PW'(req_page_index);
      sweep_ext = CMPW'(sweep_ff);
      fc_dec    = fc_ff - FW'(1);
      fc_full   = fc_ff == FullCnt;
      cur_flag  = meta_rdata[REF_BITS];
      cur_refs  = meta_rdata[REF_BITS-1:0];
      sweep_last = sweep_ff == LastPage;
   end

   // the count ram read address follows the incoming request, the stack read address the stack top
   assign meta_raddr  = req_idx;
   assign stack_raddr = fc_dec[PW-1:0];

   // next-state and datapath
   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      fc_in        = fc_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      num_pages_in = num_pages_ff;
      reserved_in  = reserved_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = pfa_pkg::ST_OK;
      rsp_given_in = '0;
      rsp_count_in = '0;
      rsp_back_in  = 1'b0;
      meta_we      = 1'b0;
      meta_waddr   = sweep_ff;
      meta_wdata   = '0;
      stack_we     = 1'b0;
      stack_waddr  = fc_ff[PW-1:0];
      stack_wdata  = sweep_ff;
      new_refs     = '0;
      push_ok      = 1'b0;

      // register writes
      if (csr_we) begin
         unique case (csr_index)
            pfa_pkg::CSR_NUM_PAGES: num_pages_in = csr_wdata;
            pfa_pkg::CSR_RESERVED:  reserved_in  = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         // clearing pass after reset
         S_CLEAR: begin
            meta_we  = 1'b1;
            sweep_in = sweep_ff + PW'(1);
            if (sweep_last) begin
               sweep_in = '0;
               state_in = S_IDLE;
            end
         end

         // accept a request and issue the ram reads
         S_IDLE: begin
            if (start) begin
               op_in  = req_type;
               idx_in = req_idx;
               priority case (req_type)
                  pfa_pkg::REQ_INIT: begin
                     fc_in    = '0;
                     sweep_in = '0;
                     state_in = S_INIT;
                  end
                  pfa_pkg::REQ_ALLOC: begin
                     if (fc_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pfa_pkg::ST_NOMEM;
                     end else begin
                        state_in = S_MOD;
                     end
                  end
                  pfa_pkg::REQ_FREE, pfa_pkg::REQ_ADD, pfa_pkg::REQ_DROP: begin
                     if (!in_range) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = pfa_pkg::ST_RANGE;
                     end else begin
                        state_in = S_MOD;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = pfa_pkg::ST_MISUSE;
                  end
               endcase
            end
         end

         // init sweep: reserved pages get count 1, present pages are pushed
         S_INIT: begin
            meta_we = 1'b1;
            if (sweep_ext < res_clip) begin
               meta_wdata = {1'b0, RefOne};
            end else if (sweep_ext < npg) begin
               meta_wdata = {1'b1, {REF_BITS{1'b0}}};
               stack_we   = 1'b1;
               fc_in      = fc_ff + FW'(1);
            end
            sweep_in = sweep_ff + PW'(1);
            if (sweep_last) begin
               sweep_in     = '0;
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end

         // modify and write back
         S_MOD: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            meta_waddr   = idx_ff;
            stack_wdata  = idx_ff;
            unique case (op_ff)
               pfa_pkg::REQ_ALLOC: begin
                  meta_we      = 1'b1;
                  meta_waddr   = stack_rdata;
                  meta_wdata   = '0;
                  fc_in        = fc_dec;
                  rsp_given_in = PageW'(stack_rdata);
               end
               pfa_pkg::REQ_FREE: begin
                  rsp_count_in = CntW'(cur_refs);
                  if (cur_flag || cur_refs != '0 || fc_full) begin
                     rsp_status_in = pfa_pkg::ST_MISUSE;
                  end else begin
                     meta_we     = 1'b1;
                     meta_wdata  = {1'b1, {REF_BITS{1'b0}}};
                     stack_we    = 1'b1;
                     fc_in       = fc_ff + FW'(1);
                     rsp_back_in = 1'b1;
                  end
               end
               pfa_pkg::REQ_ADD: begin
                  if (cur_refs == RefMax) begin
                     rsp_status_in = pfa_pkg::ST_MISUSE;
                     rsp_count_in  = CntW'(cur_refs);
                  end else begin
                     new_refs     = cur_refs + RefOne;
                     meta_we      = 1'b1;
                     meta_wdata   = {cur_flag, new_refs};
                     rsp_count_in = CntW'(new_refs);
                  end
               end
               pfa_pkg::REQ_DROP: begin
                  if (cur_refs == '0) begin
                     rsp_status_in = pfa_pkg::ST_MISUSE;
                  end else begin
                     new_refs     = cur_refs - RefOne;
                     push_ok      = (new_refs == '0) && !cur_flag && !fc_full;
                     meta_we      = 1'b1;
                     meta_wdata   = {cur_flag | push_ok, new_refs};
                     stack_we     = push_ok;
                     rsp_back_in  = push_ok;
                     rsp_count_in = CntW'(new_refs);
                     if (push_ok) begin
                        fc_in = fc_ff + FW'(1);
                     end
                  end
               end
               default: begin
                  rsp_status_in = pfa_pkg::ST_MISUSE;
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         fc_ff        <= '0;
         num_pages_ff <= pfa_pkg::NUM_PAGES_RST;
         reserved_ff  <= pfa_pkg::RESERVED_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         fc_ff        <= fc_in;
         num_pages_ff <= num_pages_in;
         reserved_ff  <= reserved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_given_ff  <= rsp_given_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_back_ff   <= rsp_back_in;
   end

   // outputs
   assign busy                 = state_ff != S_IDLE;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_given_page       = rsp_given_ff;
   assign rsp_ref_count        = rsp_count_ff;
   assign rsp_returned_to_list = rsp_back_ff;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench for the page frame allocator: directed cases, then random traffic
module testbench;

   localparam int          TB_MAX_PAGES = 1024;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int          PRINT_LIMIT  = 30;

   typedef struct packed {
      logic [pfa_pkg::STATUS_W-1:0] status;
      logic [pfa_pkg::IDX_W-1:0]    given_page;
      logic [pfa_pkg::CNT_W-1:0]    ref_count;
      logic                         returned_to_list;
   } page_answer_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [pfa_pkg::REQ_W-1:0]    req_type;
   logic [pfa_pkg::IDX_W-1:0]    req_page_index;
   logic                         rsp_valid;
   logic [pfa_pkg::STATUS_W-1:0] rsp_status;
   logic [pfa_pkg::IDX_W-1:0]    rsp_given_page;
   logic [pfa_pkg::CNT_W-1:0]    rsp_ref_count;
   logic                         rsp_returned_to_list;
   logic                         csr_we;
   logic [pfa_pkg::CSR_IX_W-1:0] csr_index;
   logic [pfa_pkg::CFG_W-1:0]    csr_wdata;

   // shadow copy of the allocator state and registers
   int unsigned               shadow_num_pages = pfa_pkg::NUM_PAGES_RST;
   int unsigned               shadow_reserved  = pfa_pkg::RESERVED_RST;
   logic [pfa_pkg::IDX_W-1:0] shadow_stack [TB_MAX_PAGES];
   int unsigned               shadow_depth = 0;
   logic [pfa_pkg::CNT_W-1:0] shadow_refs [TB_MAX_PAGES] = '{default: '0};
   bit                        shadow_listed [TB_MAX_PAGES] = '{default: 1'b0};

   page_answer_type           expected_answers [$];
   page_answer_type           checked_answer;
   logic [pfa_pkg::IDX_W-1:0] held_pages [$];

   int unsigned cycle_count    = 0;
   int unsigned requests_sent  = 0;
   int unsigned answers_seen   = 0;
   int unsigned returned_seen  = 0;
   int unsigned failures       = 0;
   int unsigned status_seen [4] = '{default: 0};
   bit          idle_off       = 1'b0;

   page_frame_allocator_top dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_type             (req_type),
      .req_page_index       (req_page_index),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_given_page       (rsp_given_page),
      .rsp_ref_count        (rsp_ref_count),
      .rsp_returned_to_list (rsp_returned_to_list),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: watchdog expired after %0d cycles", $time, cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // push a page onto the shadow free stack, refused when full
   function automatic bit push_shadow_page(input logic [pfa_pkg::IDX_W-1:0] pg);
      if (shadow_depth >= TB_MAX_PAGES) return 1'b0;
      shadow_stack[shadow_depth] = pg;
      shadow_depth++;
      shadow_listed[pg] = 1'b1;
      return 1'b1;
   endfunction

   // apply one request to the shadow state and return the answer it should give
   function automatic page_answer_type apply_page_request(
         input logic [pfa_pkg::REQ_W-1:0] kind, input logic [pfa_pkg::IDX_W-1:0] pg);
      page_answer_type           a;
      int unsigned               usable;
      int unsigned               kept;
      logic [pfa_pkg::IDX_W-1:0] top;
      a = '0;
      a.status = pfa_pkg::ST_OK;
      usable = (shadow_num_pages < TB_MAX_PAGES) ? shadow_num_pages : TB_MAX_PAGES;
      case (kind)
         pfa_pkg::REQ_INIT: begin
            kept = (shadow_reserved < usable) ? shadow_reserved : usable;
            shadow_depth = 0;
            for (int i = 0; i < TB_MAX_PAGES; i++) shadow_listed[i] = 1'b0;
            for (int i = 0; i < TB_MAX_PAGES; i++) begin
               if (i < kept) begin
                  shadow_refs[i] = 1;
               end else begin
                  shadow_refs[i] = '0;
                  if (i < usable) void'(push_shadow_page(pfa_pkg::IDX_W'(i)));
               end
            end
         end
         pfa_pkg::REQ_ALLOC: begin
            if (shadow_depth == 0) begin
               a.status = pfa_pkg::ST_NOMEM;
            end else begin
               shadow_depth--;
               top = shadow_stack[shadow_depth];
               shadow_listed[top] = 1'b0;
               shadow_refs[top] = '0;
               a.given_page = top;
            end
         end
         pfa_pkg::REQ_FREE, pfa_pkg::REQ_ADD, pfa_pkg::REQ_DROP: begin
            if (pg >= usable) begin
               a.status = pfa_pkg::ST_RANGE;
            end else if (kind == pfa_pkg::REQ_FREE) begin
               a.ref_count = shadow_refs[pg];
               if (shadow_listed[pg] || shadow_refs[pg] != 0 || !push_shadow_page(pg))
                  a.status = pfa_pkg::ST_MISUSE;
               else
                  a.returned_to_list = 1'b1;
            end else if (kind == pfa_pkg::REQ_ADD) begin
               // count saturates at all ones
               if (&shadow_refs[pg]) a.status = pfa_pkg::ST_MISUSE;
               else shadow_refs[pg]++;
               a.ref_count = shadow_refs[pg];
            end else begin
               if (shadow_refs[pg] == 0) begin
                  a.status = pfa_pkg::ST_MISUSE;
               end else begin
                  shadow_refs[pg]--;
                  // a page already on the list is not pushed twice
                  if (shadow_refs[pg] == 0 && !shadow_listed[pg] && push_shadow_page(pg))
                     a.returned_to_list = 1'b1;
               end
               a.ref_count = shadow_refs[pg];
            end
         end
         default: a.status = pfa_pkg::ST_MISUSE;
      endcase
      return a;
   endfunction

   // gap after a request: mostly none, some short, a few long
   function automatic int next_gap();
      int r;
      if (idle_off) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // issue one request, wait for acceptance, record the expected answer
   task automatic send_request(input logic [pfa_pkg::REQ_W-1:0] kind,
                               input logic [pfa_pkg::IDX_W-1:0] pg,
                               input int gap, output page_answer_type ans);
      req_type       <= kind;
      req_page_index <= pg;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
      ans = apply_page_request(kind, pg);
      expected_answers.push_back(ans);
      requests_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // let every outstanding answer arrive and the block go quiet
   task automatic wait_for_idle();
      start <= 1'b0;
      while (expected_answers.size() != 0 || busy) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // write both registers while the block is idle
   task automatic program_registers(input int unsigned pages, input int unsigned reserve);
      wait_for_idle();
      csr_we    <= 1'b1;
      csr_index <= pfa_pkg::CSR_NUM_PAGES;
      csr_wdata <= pfa_pkg::CFG_W'(pages);
      @(posedge clock);
      csr_index <= pfa_pkg::CSR_RESERVED;
      csr_wdata <= pfa_pkg::CFG_W'(reserve);
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_num_pages = pages;
      shadow_reserved  = reserve;
   endtask

   // compare one answer field
   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         failures++;
         if (failures <= PRINT_LIMIT)
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   // answer checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         answers_seen++;
         status_seen[rsp_status]++;
         if (rsp_returned_to_list) returned_seen++;
         if (expected_answers.size() == 0) begin
            failures++;
            if (failures <= PRINT_LIMIT)
               $display("%0t: unexpected answer, expected none actual status %0d page %0d",
                        $time, rsp_status, rsp_given_page);
         end else begin
            checked_answer = expected_answers.pop_front();
            check_field("status", checked_answer.status, rsp_status);
            check_field("given_page", checked_answer.given_page, rsp_given_page);
            check_field("ref_count", checked_answer.ref_count, rsp_ref_count);
            check_field("returned_to_list", checked_answer.returned_to_list,
                        rsp_returned_to_list);
         end
      end
   end

   // requests before any init: empty list, zero counts
   task automatic test_reset_state();
      page_answer_type ans;
      send_request(pfa_pkg::REQ_ALLOC, 10'd0, 1, ans);
      send_request(pfa_pkg::REQ_DROP, 10'd5, 0, ans);
      send_request(pfa_pkg::REQ_FREE, 10'd7, 2, ans);
      send_request(pfa_pkg::REQ_FREE, 10'd7, 0, ans);
      send_request(pfa_pkg::REQ_ALLOC, 10'd0, 1, ans);
   endtask

   // small pool: exhaustion, misuse, range and unknown codes
   task automatic test_small_pool();
      page_answer_type ans;
      program_registers(4, 1);
      send_request(pfa_pkg::REQ_INIT, 10'd0, 0, ans);
      repeat (4) send_request(pfa_pkg::REQ_ALLOC, 10'd0, 0, ans);
      // reserved page has count 1, then drops back onto the list
      send_request(pfa_pkg::REQ_FREE, 10'd0, 1, ans);
      send_request(pfa_pkg::REQ_DROP, 10'd0, 0, ans);
      send_request(pfa_pkg::REQ_FREE, 10'd3, 0, ans);
      send_request(pfa_pkg::REQ_FREE, 10'd3, 3, ans);
      // reference on a listed page, drop to zero leaves it listed once
      send_request(pfa_pkg::REQ_ADD, 10'd3, 0, ans);
      send_request(pfa_pkg::REQ_DROP, 10'd3, 0, ans);
      send_request(pfa_pkg::REQ_ADD, 10'd4, 1, ans);
      send_request(pfa_pkg::REQ_DROP, 10'd1023, 0, ans);
      send_request(3'd5, 10'd1, 0, ans);
      send_request(3'd6, 10'd2, 0, ans);
      send_request(3'd7, 10'd1023, 2, ans);
      send_request(pfa_pkg::REQ_ALLOC, 10'd0, 0, ans);
      send_request(pfa_pkg::REQ_DROP, 10'd2, 1, ans);
   endtask

   // stack references on one page, then release them until it returns to the list
   task automatic test_count_run();
      page_answer_type ans;
      program_registers(1024, 0);
      send_request(pfa_pkg::REQ_INIT, 10'd0, 0, ans);
      send_request(pfa_pkg::REQ_ALLOC, 10'd0, 0, ans);
      for (int n = 0; n < 6; n++) send_request(pfa_pkg::REQ_ADD, 10'd1023, 0, ans);
      // free with references held is refused
      send_request(pfa_pkg::REQ_FREE, 10'd1023, 1, ans);
      for (int n = 0; n < 6; n++) send_request(pfa_pkg::REQ_DROP, 10'd1023, 0, ans);
      send_request(pfa_pkg::REQ_DROP, 10'd1023, 1, ans);
      send_request(pfa_pkg::REQ_DROP, 10'd0, 2, ans);
   endtask

   // one register setting, init, then mostly sensible alloc/free/ref traffic
   task automatic run_traffic_phase(input int unsigned pages, input int unsigned reserve,
                                    input int unsigned count);
      page_answer_type           ans;
      int                        r;
      int                        k;
      int unsigned               usable;
      logic [pfa_pkg::REQ_W-1:0] kind;
      logic [pfa_pkg::IDX_W-1:0] pg;
      program_registers(pages, reserve);
      usable = (pages < TB_MAX_PAGES) ? pages : TB_MAX_PAGES;
      send_request(pfa_pkg::REQ_INIT, pfa_pkg::IDX_W'($urandom), next_gap(), ans);
      held_pages.delete();
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 49) == 0) idle_off = !idle_off;
         r = $urandom_range(0, 99);
         k = -1;
         if (r < 4) begin
            kind = pfa_pkg::REQ_W'($urandom_range(5, 7));
            pg   = pfa_pkg::IDX_W'($urandom);
         end else if (r < 9) begin
            kind = pfa_pkg::REQ_W'($urandom_range(pfa_pkg::REQ_ALLOC, pfa_pkg::REQ_DROP));
            pg   = pfa_pkg::IDX_W'($urandom);
         end else if (r < 10) begin
            kind = pfa_pkg::REQ_INIT;
            pg   = pfa_pkg::IDX_W'($urandom);
         end else if (r < 40) begin
            kind = pfa_pkg::REQ_ALLOC;
            pg   = pfa_pkg::IDX_W'($urandom);
         end else begin
            if (held_pages.size() != 0) begin
               k  = $urandom_range(0, held_pages.size() - 1);
               pg = held_pages[k];
            end else begin
               pg = pfa_pkg::IDX_W'($urandom_range(0, usable - 1));
            end
            r = $urandom_range(0, 99);
            kind = (r < 35) ? pfa_pkg::REQ_FREE :
                   (r < 70) ? pfa_pkg::REQ_ADD : pfa_pkg::REQ_DROP;
         end
         send_request(kind, pg, next_gap(), ans);
         // keep the list of pages this side owns in step
         if (kind == pfa_pkg::REQ_INIT) held_pages.delete();
         else if (ans.returned_to_list && k >= 0) held_pages.delete(k);
         if (kind == pfa_pkg::REQ_ALLOC && ans.status == pfa_pkg::ST_OK)
            held_pages.push_back(ans.given_page);
      end
      idle_off = 1'b0;
   endtask

   // random traffic over several pool shapes, extremes included
   task automatic test_random_traffic();
      int unsigned pool_sizes [8]    = '{1024, 1, 1, 2, 8, 33, 1024, 1000};
      int unsigned reserve_sizes [8] = '{0, 0, 1, 0, 3, 40, 1024, 1};
      for (int p = 0; p < 8; p++) run_traffic_phase(pool_sizes[p], reserve_sizes[p], 135);
      repeat (2) run_traffic_phase($urandom_range(1, 1024), $urandom_range(0, 1024), 135);
   endtask

   // test sequence
   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_type       <= pfa_pkg::REQ_INIT;
      req_page_index <= '0;
      csr_we         <= 1'b0;
      csr_index      <= pfa_pkg::CSR_NUM_PAGES;
      csr_wdata      <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_small_pool();
      test_count_run();
      test_random_traffic();

      wait_for_idle();
      repeat (4) @(posedge clock);
      failures += expected_answers.size();

      $display("%0d requests sent, %0d answers checked, %0d pages went back to the list",
               requests_sent, answers_seen, returned_seen);
      $display("status ok %0d, no memory %0d, misuse %0d, out of range %0d; %0d failures",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], failures);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
